[rtl/b64lw_pkg.sv]
// Shared types and constants for the line-wrapping base64 encoder.
// Used by b64lw_encode, b64lw_serializer and the top level; no dependencies.
package b64lw_pkg;

  // Request codes carried in the req_type field.
  localparam logic [1:0] REQ_DATA  = 2'd0;
  localparam logic [1:0] REQ_FLUSH = 2'd1;
  localparam logic [1:0] REQ_INIT  = 2'd2;

  // Characters that the encoder inserts.
  localparam logic [7:0] CHAR_LF  = 8'h0A;
  localparam logic [7:0] CHAR_CR  = 8'h0D;
  localparam logic [7:0] CHAR_PAD = 8'h3D;

  localparam logic [5:0] GPL_RESET = 6'd18;

  // Most characters that a single request can produce.
  localparam int RES_SLOTS = 5;
  localparam int CNT_W     = $clog2(RES_SLOTS + 1);

  typedef struct packed {
    logic [1:0] req_type;
    logic [7:0] data_byte;
  } in_t;

  typedef struct packed {
    logic [7:0] out_char;
    logic       last_of_run;
  } out_t;

  // Characters produced by one request, slot 0 goes out first.
  typedef struct packed {
    logic [RES_SLOTS-1:0][7:0] chars;
    logic [CNT_W-1:0]          count;
  } res_t;

endpackage

[rtl/b64lw_encode.sv]
// Encoder state and per-request character generation.
// Depends on b64lw_pkg.
module b64lw_encode (
  input  logic             clk,
  input  logic             rst,
  input  b64lw_pkg::in_t   item,
  input  logic             fire,
  input  logic [5:0]       groups_per_line,
  output b64lw_pkg::res_t  res
);
  import b64lw_pkg::*;

  typedef struct packed {
    logic [23:0] bits;
    logic [1:0]  pos;
    logic [5:0]  gc;
  } st_t;

  typedef struct packed {
    st_t             st;
    logic            done;
    logic            lf;
    logic [3:0][7:0] ch;
  } take_t;

  st_t st;
  st_t st_next;

  function automatic logic [7:0] sextet_char(input logic [5:0] v);
    logic [7:0] w;
    w = {2'b00, v};
    if (v < 6'd26) return 8'h41 + w;
    else if (v < 6'd52) return 8'h61 + w - 8'd26;
    else if (v < 6'd62) return 8'h30 + w - 8'd52;
    else if (v == 6'd62) return 8'h2B;
    else return 8'h2F;
  endfunction

  // Adds one byte to the group; a full group yields four characters and
  // possibly a line feed when the line is full.
  function automatic take_t take(input st_t s, input logic [7:0] ch,
                                 input logic [5:0] gpl);
    take_t r;
    logic [23:0] p;
    logic [5:0]  g;
    p = (s.pos == 2'd0) ? {16'h0000, ch} : {s.bits[15:0], ch};
    r = '0;
    r.st.bits = p;
    r.st.pos  = s.pos + 2'd1;
    r.st.gc   = s.gc;
    if (r.st.pos == 2'd3) begin
      g         = s.gc + 6'd1;
      r.done    = 1'b1;
      r.ch[0]   = sextet_char(p[23:18]);
      r.ch[1]   = sextet_char(p[17:12]);
      r.ch[2]   = sextet_char(p[11:6]);
      r.ch[3]   = sextet_char(p[5:0]);
      r.st.pos  = 2'd0;
      r.st.gc   = g;
      if (g == gpl) begin
        r.lf    = 1'b1;
        r.st.gc = 6'd0;
      end
    end
    return r;
  endfunction

  take_t       t_cr;
  take_t       t_byte;
  take_t       t_sel;
  logic        is_lf;
  logic [23:0] p2;
  logic [23:0] p4;

  always_comb begin
    is_lf   = (item.data_byte == CHAR_LF);
    // A line feed byte is encoded after an inserted carriage return.
    t_cr    = take(st, CHAR_CR, groups_per_line);
    t_byte  = take(is_lf ? t_cr.st : st, item.data_byte, groups_per_line);
    // At most one of the two bytes can complete a group.
    t_sel   = (is_lf && t_cr.done) ? t_cr : t_byte;
    p2      = {st.bits[21:0], 2'b00};
    p4      = {st.bits[19:0], 4'b0000};
    st_next = st;
    res     = '0;
    unique case (item.req_type)
      REQ_DATA: begin
        st_next = t_byte.st;
        if (t_sel.done) begin
          res.chars[0] = t_sel.ch[0];
          res.chars[1] = t_sel.ch[1];
          res.chars[2] = t_sel.ch[2];
          res.chars[3] = t_sel.ch[3];
          res.chars[4] = CHAR_LF;
          res.count    = t_sel.lf ? CNT_W'(5) : CNT_W'(4);
        end
      end
      REQ_FLUSH: begin
        res.count = CNT_W'(5);
        if (st.pos == 2'd2) begin
          st_next.bits = p2;
          res.chars[0] = sextet_char(p2[17:12]);
          res.chars[1] = sextet_char(p2[11:6]);
          res.chars[2] = sextet_char(p2[5:0]);
          res.chars[3] = CHAR_PAD;
          res.chars[4] = CHAR_LF;
        end else if (st.pos == 2'd1) begin
          st_next.bits = p4;
          res.chars[0] = sextet_char(p4[11:6]);
          res.chars[1] = sextet_char(p4[5:0]);
          res.chars[2] = CHAR_PAD;
          res.chars[3] = CHAR_PAD;
          res.chars[4] = CHAR_LF;
        end else begin
          res.chars[0] = CHAR_LF;
          res.count    = CNT_W'(1);
        end
      end
      REQ_INIT: begin
        st_next.pos = 2'd0;
        st_next.gc  = 6'd0;
      end
      default: begin
        st_next = st;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      st <= '0;
    end else if (fire) begin
      st <= st_next;
    end
  end

endmodule

[rtl/b64lw_serializer.sv]
// Result buffer that hands out one request's characters, one per ready cycle.
// Depends on b64lw_pkg.
module b64lw_serializer (
  input  logic             clk,
  input  logic             rst,
  input  b64lw_pkg::res_t  res,
  input  logic             load,
  input  logic             chr_ready,
  output logic             chr_valid,
  output b64lw_pkg::out_t  chr_item,
  output logic             free
);
  import b64lw_pkg::*;

  logic [RES_SLOTS-1:0][7:0] chars;
  logic [CNT_W-1:0]          cnt;
  logic                      take_chr;

  assign chr_valid            = (cnt != '0);
  assign take_chr             = chr_valid && chr_ready;
  assign chr_item.out_char    = chars[0];
  assign chr_item.last_of_run = (cnt == CNT_W'(1));
  assign free                 = (cnt == '0) || (chr_ready && cnt == CNT_W'(1));

  always_ff @(posedge clk) begin
    if (rst) begin
      cnt <= '0;
    end else if (load) begin
      cnt <= res.count;
    end else if (take_chr) begin
      cnt <= cnt - CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      chars <= res.chars;
    end else if (take_chr) begin
      chars <= {8'h00, chars[RES_SLOTS-1:1]};
    end
  end

endmodule

[rtl/base64_line_wrapping_encoder_unit.sv]
// A request is registered in the input register at acceptance and encoded
// from there; its characters load into the result buffer once that is free.
// Throughput: one request per cycle unless the held request waits for the
// result buffer, which sends one character per cycle while chr_ready is high.
// Reset (rst, synchronous): counters, byte position and bits clear, buffer
// empties, groups_per_line returns to 18.
module base64_line_wrapping_encoder_unit (
  input  logic             clk,
  input  logic             rst,
  input  logic             req_valid,
  output logic             req_ready,
  input  b64lw_pkg::in_t   req_item,
  output logic             chr_valid,
  input  logic             chr_ready,
  output b64lw_pkg::out_t  chr_item,
  input  logic             cfg_we,
  input  logic [5:0]       cfg_wdata
);
  import b64lw_pkg::*;

  // Line length register, written directly by the configuration port.
  logic [5:0] groups_per_line;

  // Input register: holds one request until the encoder can take it.
  in_t  hold;
  logic hold_full;

  // Encoder result for the held request, and handoff control.
  res_t res;
  logic buf_free;
  logic advance;
  logic load;

  always_ff @(posedge clk) begin
    if (rst) begin
      groups_per_line <= GPL_RESET;
    end else if (cfg_we) begin
      groups_per_line <= cfg_wdata;
    end
  end

  // The held request moves on when it produces no characters (init, unused
  // codes, partial groups) or when the result buffer is empty or emptying in
  // this cycle. Its state update happens at that same edge, so requests keep order.
  assign advance   = hold_full && ((res.count == '0) || buf_free);
  assign load      = advance && (res.count != '0);
  assign req_ready = !hold_full || advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      hold_full <= 1'b0;
    end else if (req_valid && req_ready) begin
      hold_full <= 1'b1;
    end else if (advance) begin
      hold_full <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (req_valid && req_ready) begin
      hold <= req_item;
    end
  end

  b64lw_encode u_encode (
    .clk             (clk),
    .rst             (rst),
    .item            (hold),
    .fire            (advance),
    .groups_per_line (groups_per_line),
    .res             (res)
  );

  b64lw_serializer u_serializer (
    .clk       (clk),
    .rst       (rst),
    .res       (res),
    .load      (load),
    .chr_ready (chr_ready),
    .chr_valid (chr_valid),
    .chr_item  (chr_item),
    .free      (buf_free)
  );

  // A request never yields a character count other than none, one line
  // feed, a group of four, or five.
  a_count_legal : assert property (@(posedge clk) disable iff (rst)
    hold_full |-> (res.count == CNT_W'(0) || res.count == CNT_W'(1) ||
                   res.count == CNT_W'(4) || res.count == CNT_W'(5)))
    else $error("illegal character count from encoder");

  // A flush always ends its line; an init never emits anything.
  a_flush_emits : assert property (@(posedge clk) disable iff (rst)
    (hold_full && hold.req_type == REQ_FLUSH) |-> (res.count != '0))
    else $error("flush produced no characters");

  a_init_silent : assert property (@(posedge clk) disable iff (rst)
    (hold_full && hold.req_type == REQ_INIT) |-> (res.count == '0))
    else $error("init produced characters");

  // Loading the buffer leaves a character on offer in the next cycle.
  a_load_offers : assert property (@(posedge clk) disable iff (rst)
    load |=> chr_valid)
    else $error("loaded result not offered");

endmodule

[sim/base64_line_wrapping_encoder_unit_tb.sv]
// Self-checking testbench for base64_line_wrapping_encoder_unit: directed and random requests.
// A scoreboard class predicts every encoded character and checks it as it leaves the block.
// Depends on rtl/b64lw_pkg.sv and rtl/base64_line_wrapping_encoder_unit.sv.
`timescale 1ns / 1ps

module base64_line_wrapping_encoder_unit_tb;
  import b64lw_pkg::*;

  // The block ignores the fourth request code; the package gives it no name.
  localparam logic [1:0] REQ_UNUSED = 2'd3;

  // Cycles without any handshake before the run is declared hung. The slowest
  // legitimate quiet stretch is a register write pause plus a few random stalls.
  localparam int WATCHDOG_LIMIT = 1000;

  // Cycles allowed after the last expected character for a request that makes
  // no characters (init, unused code, byte completing no group) to leave the pipeline.
  localparam int SETTLE_CYCLES = 8;

  // Scoreboard: keeps its own copy of the encoder state and the line length,
  // turns each accepted request into the characters it must produce, and
  // compares each character that leaves the block with the oldest of them.
  class b64_stream_tracker;
    logic [5:0]  line_groups;
    logic [23:0] group_bits;
    logic [1:0]  group_fill;
    logic [5:0]  line_fill;
    logic [7:0]  run_chars[$];
    out_t        awaited[$];
    int          errors;

    function new();
      line_groups = GPL_RESET;
      group_bits  = '0;
      group_fill  = '0;
      line_fill   = '0;
      errors      = 0;
    endfunction

    function logic [7:0] sextet_char(logic [5:0] s);
      if (s < 6'd26) return "A" + {2'b00, s};
      if (s < 6'd52) return "a" + {2'b00, s} - 8'd26;
      if (s < 6'd62) return "0" + {2'b00, s} - 8'd52;
      if (s == 6'd62) return "+";
      return "/";
    endfunction

    function void encode_byte(logic [7:0] b);
      if (group_fill == 2'd0) group_bits = {16'h0000, b};
      else group_bits = {group_bits[15:0], b};
      group_fill = group_fill + 2'd1;
      if (group_fill == 2'd3) begin
        run_chars.push_back(sextet_char(group_bits[23:18]));
        run_chars.push_back(sextet_char(group_bits[17:12]));
        run_chars.push_back(sextet_char(group_bits[11:6]));
        run_chars.push_back(sextet_char(group_bits[5:0]));
        // The group counter is six bits wide and wraps; a line feed goes out
        // only on an exact match with the configured line length.
        line_fill = line_fill + 6'd1;
        if (line_fill == line_groups) begin
          run_chars.push_back(CHAR_LF);
          line_fill = '0;
        end
        group_fill = 2'd0;
      end
    endfunction

    function void note_request(in_t r);
      case (r.req_type)
        REQ_DATA: begin
          // A line feed byte is encoded as a carriage return and a line feed.
          if (r.data_byte == CHAR_LF) encode_byte(CHAR_CR);
          encode_byte(r.data_byte);
        end
        REQ_FLUSH: begin
          // The partial group is shifted in place and the position is kept,
          // so later bytes keep filling the same group.
          if (group_fill == 2'd2) begin
            group_bits = group_bits << 2;
            run_chars.push_back(sextet_char(group_bits[17:12]));
            run_chars.push_back(sextet_char(group_bits[11:6]));
            run_chars.push_back(sextet_char(group_bits[5:0]));
            run_chars.push_back(CHAR_PAD);
          end else if (group_fill == 2'd1) begin
            group_bits = group_bits << 4;
            run_chars.push_back(sextet_char(group_bits[11:6]));
            run_chars.push_back(sextet_char(group_bits[5:0]));
            run_chars.push_back(CHAR_PAD);
            run_chars.push_back(CHAR_PAD);
          end
          run_chars.push_back(CHAR_LF);
        end
        REQ_INIT: begin
          group_fill = '0;
          line_fill  = '0;
        end
        default: ;
      endcase
      while (run_chars.size() != 0) begin
        out_t c;
        c.out_char    = run_chars.pop_front();
        c.last_of_run = (run_chars.size() == 0);
        awaited.push_back(c);
      end
    endfunction

    function void check_char(out_t got);
      out_t want;
      if (awaited.size() == 0) begin
        errors++;
        $display("%0t: unexpected character, expected none, actual %h last %b",
                 $time, got.out_char, got.last_of_run);
        return;
      end
      want = awaited.pop_front();
      if (got.out_char !== want.out_char) begin
        errors++;
        $display("%0t: out_char mismatch, expected %h, actual %h",
                 $time, want.out_char, got.out_char);
      end
      if (got.last_of_run !== want.last_of_run) begin
        errors++;
        $display("%0t: last_of_run mismatch on %h, expected %b, actual %b",
                 $time, want.out_char, want.last_of_run, got.last_of_run);
      end
    endfunction
  endclass

  logic       clk = 1'b0;
  logic       rst = 1'b1;
  logic       req_valid = 1'b0;
  logic       req_ready;
  in_t        req_item = '0;
  logic       chr_valid;
  logic       chr_ready = 1'b0;
  out_t       chr_item;
  logic       cfg_we = 1'b0;
  logic [5:0] cfg_wdata = '0;

  // Idle percentages for the request side and the character side.
  int tx_idle_pct = 0;
  int rx_idle_pct = 0;
  int quiet_cycles = 0;

  b64_stream_tracker tracker;

  base64_line_wrapping_encoder_unit u_dut (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_ready (req_ready),
    .req_item  (req_item),
    .chr_valid (chr_valid),
    .chr_ready (chr_ready),
    .chr_item  (chr_item),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // The character side stalls at random in the idle percentage of cycles.
  always @(posedge clk) begin
    chr_ready <= (rx_idle_pct == 0) || ($urandom_range(99) >= rx_idle_pct);
  end

  // Every character taken from the block is checked at the edge that takes it.
  // Values read here are those from before the edge, so there is no race.
  always @(posedge clk) begin
    if (!rst && chr_valid && chr_ready) tracker.check_char(chr_item);
  end

  // The watchdog restarts on any handshake and ends a run that has hung.
  always @(posedge clk) begin
    if ((req_valid && req_ready) || (chr_valid && chr_ready)) quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("base64_line_wrapping_encoder_unit_tb: done, errors");
      $finish;
    end
  end

  // Offers one request and returns at the edge that accepts it. Valid is
  // lowered only when an idle gap precedes the request, so it is never
  // lowered and raised again in one time step.
  task automatic send_req(input logic [1:0] kind, input logic [7:0] value);
    in_t item;
    item.req_type  = kind;
    item.data_byte = value;
    if (tx_idle_pct != 0 && $urandom_range(99) < tx_idle_pct) begin
      req_valid <= 1'b0;
      do @(posedge clk); while ($urandom_range(99) < tx_idle_pct);
    end
    req_valid <= 1'b1;
    req_item  <= item;
    do @(posedge clk); while (!req_ready);
    tracker.note_request(item);
  endtask

  // Stops offering requests and waits until every predicted character has
  // come out, then a few more cycles for requests that produce nothing.
  task automatic drain_chars();
    req_valid <= 1'b0;
    @(posedge clk);
    while (tracker.awaited.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // Line length writes happen only with the block idle.
  task automatic set_line_groups(input logic [5:0] groups);
    drain_chars();
    cfg_we    <= 1'b1;
    cfg_wdata <= groups;
    @(posedge clk);
    cfg_we <= 1'b0;
    tracker.line_groups = groups;
  endtask

  // Random requests. A data-only burst leans on line feed bytes, which
  // count as two bytes each, so the group counter moves quickly.
  task automatic random_requests(input int count, input int lf_pct, input bit data_only);
    int pick;
    logic [7:0] value;
    for (int i = 0; i < count; i++) begin
      pick  = $urandom_range(99);
      value = 8'($urandom_range(255));
      if (!data_only && pick < 12) send_req(REQ_FLUSH, value);
      else if (!data_only && pick < 16) send_req(REQ_INIT, value);
      else if (!data_only && pick < 19) send_req(REQ_UNUSED, value);
      else begin
        if ($urandom_range(99) < lf_pct) value = CHAR_LF;
        send_req(REQ_DATA, value);
      end
    end
  endtask

  initial begin
    tracker = new();
    tx_idle_pct = 30;
    rx_idle_pct = 50;
    repeat (11) @(posedge clk);
    rst <= 1'b0;

    // Directed part, at the reset line length of 18 groups.
    // Extreme byte values give all-'A' and all-'/' groups.
    send_req(REQ_DATA, 8'h00);
    send_req(REQ_DATA, 8'h00);
    send_req(REQ_DATA, 8'h00);
    send_req(REQ_DATA, 8'hFF);
    send_req(REQ_DATA, 8'hFF);
    send_req(REQ_DATA, 8'hFF);
    // A line feed byte brings its carriage return along; the flush then pads
    // a two-byte group, which is the longest run of characters.
    send_req(REQ_DATA, CHAR_LF);
    send_req(REQ_FLUSH, 8'h00);
    // The flush kept the position, so this byte completes the shifted group.
    send_req(REQ_DATA, 8'h41);
    // One-byte group, flushed twice to see the bits shift a second time.
    send_req(REQ_DATA, 8'h80);
    send_req(REQ_FLUSH, 8'hFF);
    send_req(REQ_FLUSH, 8'h00);
    // The unused request code must be ignored whatever the byte holds.
    send_req(REQ_UNUSED, 8'hA5);
    send_req(REQ_UNUSED, 8'h5A);
    // Init clears the counters; a flush of an empty group is a bare line feed.
    send_req(REQ_INIT, 8'h00);
    send_req(REQ_FLUSH, 8'h00);
    // A line feed byte landing at position one completes the group itself.
    send_req(REQ_DATA, 8'h55);
    send_req(REQ_DATA, CHAR_LF);

    // Longest line, then a group to bring the line count to two.
    set_line_groups(6'd63);
    send_req(REQ_DATA, 8'hC3);
    send_req(REQ_DATA, 8'h3C);
    send_req(REQ_DATA, 8'h7E);

    // Shortest line. The new length is below the current count, so an init
    // restarts the count; from then on a line feed follows every group.
    set_line_groups(6'd1);
    send_req(REQ_INIT, 8'h00);
    random_requests(40, 25, 1'b1);

    // Second phase: the idling is swapped and the line length is random.
    drain_chars();
    tx_idle_pct = 50;
    rx_idle_pct = 30;
    set_line_groups(6'($urandom_range(2, 62)));
    random_requests(30, 10, 1'b0);

    // Last phase: no idling on either side, short lines.
    drain_chars();
    tx_idle_pct = 0;
    rx_idle_pct = 0;
    set_line_groups(6'($urandom_range(1, 6)));
    random_requests(30, 10, 1'b0);

    drain_chars();
    if (tracker.errors == 0) begin
      $display("base64_line_wrapping_encoder_unit_tb: done, clean");
    end else begin
      $display("base64_line_wrapping_encoder_unit_tb: done, errors");
    end
    $finish;
  end

endmodule
